### rtl/core/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mtep_pkg;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_TRACK   = 2'd0;
  localparam logic [1:0] REQ_REFRESH = 2'd1;
  localparam logic [1:0] REQ_NEWTRK  = 2'd2;
  // Unused request code; the block ignores it.
  localparam logic [1:0] REQ_NONE    = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_DELTA = 3'd0;
  localparam logic [2:0] KIND_SHORT = 3'd1;
  localparam logic [2:0] KIND_TEMPO = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_SYSEX = 3'd4;

  // Configuration register indexes.
  localparam logic [0:0] CFG_TRANSPOSE = 1'd0;
  localparam logic [0:0] CFG_VOL_SCALE = 1'd1;

  // Byte constants of the file format.
  localparam logic [7:0] META_END    = 8'h2f;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] ST_SYSEX    = 8'hf0;
  localparam logic [7:0] ST_META     = 8'hff;
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_CTRL     = 4'hb;
  localparam logic [3:0] HI_PROGRAM  = 4'hc;
  localparam logic [3:0] HI_PRESSURE = 4'hd;
  localparam logic [3:0] HI_SYSTEM   = 4'hf;
  localparam logic [7:0] CC_BANK     = 8'd0;
  localparam logic [7:0] CC_VOLUME   = 8'd7;
  localparam logic [7:0] CC_PAN      = 8'd10;
  localparam logic [7:0] CC_EFFECT1  = 8'd91;
  localparam logic [7:0] CC_EFFECT3  = 8'd93;
  localparam logic [6:0] VOL_MAX     = 7'd127;
  localparam logic [7:0] VOL_SCALE_RESET = 8'd128;
  localparam logic [23:0] TEMPO_RESET = 24'd1000000;

  // Parse phases of the front end.
  typedef enum logic [3:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_SYSEX_LEN,
    PH_SYSEX_DATA,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_DATA
  } phase_t;

  // States of the back end.
  typedef enum logic {
    BK_IDLE,
    BK_REFRESH
  } bk_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] track_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [6:0]  data2;
    logic [27:0] value;
    logic        last;
  } out_item_t;

  // One command passed from the front to the back.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [27:0] value;
    logic        last;
    logic        scale;
    logic        refresh;
    logic        vol_we;
    logic [3:0]  vol_ch;
    logic [6:0]  vol_val;
  } cmd_t;

endpackage

### rtl/core/mtep_fifo.sv
// Short command queue between the parser front and the result back end.
// Depends on mtep_pkg for the command type.
module mtep_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mtep_pkg::cmd_t push_data,
  input  logic           pop,
  output mtep_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mtep_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));
  assign head  = mem[rd_ptr_r];

  // Storage is written on every push transfer.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

### rtl/core/mtep_front.sv
// Parser front end: accepts track bytes and requests, runs the parse phases,
// keeps per-channel state and pushes one command per result. Uses mtep_pkg.
module mtep_front #(
  parameter int NUM_CHANNELS = 16,
  parameter int VLQ_BITS     = 28
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  mtep_pkg::in_item_t item,
  input  logic [6:0]         transpose,
  output logic               push,
  output mtep_pkg::cmd_t     cmd
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  mtep_pkg::phase_t ph_r, ph_nxt;
  logic [7:0]          rs_r, rs_nxt;
  logic [VLQ_BITS-1:0] acc_r, acc_nxt;
  logic [VLQ_BITS-1:0] rem_r, rem_nxt;
  logic [7:0]          meta_r, meta_nxt;
  logic [7:0]          latch_r, latch_nxt;
  logic [23:0]         tempo_r, tempo_nxt;
  logic                halt_r, halt_nxt;

  logic [127:0] key_map_r [NUM_CHANNELS];
  logic [6:0]   prog_r [NUM_CHANNELS];
  logic [6:0]   bank_r [NUM_CHANNELS];
  logic [6:0]   pan_r  [NUM_CHANNELS];
  logic [6:0]   fx1_r  [NUM_CHANNELS];
  logic [6:0]   fx3_r  [NUM_CHANNELS];

  logic [7:0]          b;
  mtep_pkg::phase_t    ph_e;
  logic [VLQ_BITS-1:0] acc_e, vlq, rem_dec;
  logic                feed_en, cm, md, inr;
  logic [7:0]          cd1, cd2;
  logic [VLQ_BITS-1:0] md_rem;
  logic [23:0]         md_tempo;
  logic                key_we, key_on, prog_we, bank_we, pan_we, fx1_we, fx3_we;
  logic [6:0]          key_idx, note;
  logic [CH_W-1:0]     ch_idx;

  // Phase that a status byte leads into.
  function automatic mtep_pkg::phase_t status_phase(input logic [7:0] st);
    mtep_pkg::phase_t p;
    if (st == mtep_pkg::ST_SYSEX) begin
      p = mtep_pkg::PH_SYSEX_LEN;
    end else if (st == mtep_pkg::ST_META) begin
      p = mtep_pkg::PH_META_TYPE;
    end else if (st[7:4] == mtep_pkg::HI_SYSTEM) begin
      p = mtep_pkg::PH_DELTA;
    end else begin
      p = mtep_pkg::PH_DATA1;
    end
    return p;
  endfunction

  assign b       = item.track_byte;
  assign vlq     = VLQ_BITS'({acc_e, b[6:0]});
  assign rem_dec = rem_r - 1'b1;
  assign inr     = (32'(rs_r[3:0]) < NUM_CHANNELS);
  assign ch_idx  = CH_W'(rs_r[3:0]);
  assign note    = 7'(cd1[6:0] + transpose);

  // Parse step: next state and the command pushed for this transfer.
  always_comb begin
    ph_nxt    = ph_r;
    rs_nxt    = rs_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    meta_nxt  = meta_r;
    latch_nxt = latch_r;
    tempo_nxt = tempo_r;
    halt_nxt  = halt_r;
    push      = 1'b0;
    cmd       = '0;
    ph_e      = ph_r;
    acc_e     = acc_r;
    feed_en   = 1'b0;
    cm        = 1'b0;
    md        = 1'b0;
    cd1       = b;
    cd2       = '0;
    md_rem    = rem_r;
    md_tempo  = tempo_r;
    key_we    = 1'b0;
    key_on    = 1'b0;
    key_idx   = note;
    prog_we   = 1'b0;
    bank_we   = 1'b0;
    pan_we    = 1'b0;
    fx1_we    = 1'b0;
    fx3_we    = 1'b0;

    if (fire) begin
      case (item.req_type)
        mtep_pkg::REQ_TRACK: begin
          if (!halt_r) begin
            feed_en = 1'b1;
            // A status slot either takes a new status or falls through.
            if (ph_r == mtep_pkg::PH_STATUS) begin
              acc_e = '0;
              if (b[7]) begin
                rs_nxt  = b;
                ph_nxt  = status_phase(b);
                acc_nxt = '0;
                feed_en = 1'b0;
              end else if (!rs_r[7]) begin
                ph_e = mtep_pkg::PH_DELTA;
              end else begin
                ph_e = status_phase(rs_r);
              end
            end
          end
        end
        mtep_pkg::REQ_REFRESH: begin
          push        = 1'b1;
          cmd.refresh = 1'b1;
        end
        mtep_pkg::REQ_NEWTRK: begin
          ph_nxt    = mtep_pkg::PH_DELTA;
          rs_nxt    = '0;
          acc_nxt   = '0;
          rem_nxt   = '0;
          meta_nxt  = '0;
          latch_nxt = '0;
          halt_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // One byte in the effective phase.
    if (feed_en) begin
      case (ph_e)
        mtep_pkg::PH_DELTA: begin
          acc_nxt = vlq;
          if (!b[7]) begin
            push      = 1'b1;
            cmd.kind  = mtep_pkg::KIND_DELTA;
            cmd.value = 28'(vlq);
            acc_nxt   = '0;
            ph_nxt    = mtep_pkg::PH_STATUS;
          end
        end
        mtep_pkg::PH_DATA1: begin
          if (rs_r[7:4] == mtep_pkg::HI_PROGRAM || rs_r[7:4] == mtep_pkg::HI_PRESSURE) begin
            cm  = 1'b1;
            cd1 = b;
            cd2 = '0;
          end else begin
            latch_nxt = b;
            ph_nxt    = mtep_pkg::PH_DATA2;
          end
        end
        mtep_pkg::PH_DATA2: begin
          cm  = 1'b1;
          cd1 = latch_r;
          cd2 = b;
        end
        mtep_pkg::PH_SYSEX_LEN: begin
          acc_nxt = vlq;
          if (!b[7]) begin
            rem_nxt   = vlq;
            acc_nxt   = '0;
            push      = 1'b1;
            cmd.kind  = mtep_pkg::KIND_SYSEX;
            cmd.data1 = mtep_pkg::ST_SYSEX;
            cmd.last  = (vlq == '0);
            ph_nxt    = (vlq == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SYSEX_DATA;
          end
        end
        mtep_pkg::PH_SYSEX_DATA: begin
          rem_nxt   = rem_dec;
          push      = 1'b1;
          cmd.kind  = mtep_pkg::KIND_SYSEX;
          cmd.data1 = b;
          cmd.last  = (rem_dec == '0);
          if (rem_dec == '0) begin
            ph_nxt  = mtep_pkg::PH_DELTA;
            acc_nxt = '0;
          end
        end
        mtep_pkg::PH_META_TYPE: begin
          meta_nxt = b;
          acc_nxt  = '0;
          ph_nxt   = mtep_pkg::PH_META_LEN;
        end
        mtep_pkg::PH_META_LEN: begin
          acc_nxt = vlq;
          if (!b[7]) begin
            rem_nxt = vlq;
            acc_nxt = '0;
            md      = 1'b1;
            md_rem  = vlq;
            if (meta_r == mtep_pkg::META_TEMPO) begin
              tempo_nxt = '0;
              md_tempo  = '0;
            end
          end
        end
        mtep_pkg::PH_META_DATA: begin
          if (meta_r == mtep_pkg::META_TEMPO) begin
            tempo_nxt = {tempo_r[15:0], b};
            md_tempo  = {tempo_r[15:0], b};
          end
          rem_nxt = rem_dec;
          md_rem  = rem_dec;
          md      = (rem_dec == '0);
        end
        default: begin
        end
      endcase
    end

    // Close of a meta event.
    if (md) begin
      ph_nxt  = mtep_pkg::PH_DELTA;
      acc_nxt = '0;
      if (meta_r == mtep_pkg::META_END) begin
        halt_nxt = 1'b1;
        push     = 1'b1;
        cmd.kind = mtep_pkg::KIND_END;
      end else if (meta_r == mtep_pkg::META_TEMPO && md_rem == '0) begin
        push      = 1'b1;
        cmd.kind  = mtep_pkg::KIND_TEMPO;
        cmd.value = {4'd0, md_tempo};
      end else if (md_rem != '0) begin
        ph_nxt = mtep_pkg::PH_META_DATA;
      end
    end

    // Channel message: key map, per-channel stores and the short result.
    if (cm) begin
      push       = 1'b1;
      cmd.kind   = mtep_pkg::KIND_SHORT;
      cmd.status = rs_r;
      cmd.data1  = cd1;
      cmd.data2  = {1'b0, cd2[6:0]};
      ph_nxt     = mtep_pkg::PH_DELTA;
      acc_nxt    = '0;
      if (rs_r[7:4] == mtep_pkg::HI_NOTE_ON || rs_r[7:4] == mtep_pkg::HI_NOTE_OFF) begin
        cmd.data1 = {1'b0, note};
        key_we    = inr;
        key_on    = (rs_r[7:4] == mtep_pkg::HI_NOTE_ON) && (cd2 != '0);
      end else if (rs_r[7:4] == mtep_pkg::HI_PROGRAM) begin
        prog_we = inr;
      end else if (rs_r[7:4] == mtep_pkg::HI_CTRL) begin
        if (cd1 == mtep_pkg::CC_VOLUME) begin
          cmd.data2   = cd2;
          cmd.scale   = 1'b1;
          cmd.vol_we  = inr;
          cmd.vol_ch  = rs_r[3:0];
          cmd.vol_val = cd2[6:0];
        end else begin
          bank_we = inr && (cd1 == mtep_pkg::CC_BANK);
          fx1_we  = inr && (cd1 == mtep_pkg::CC_EFFECT1);
          fx3_we  = inr && (cd1 == mtep_pkg::CC_EFFECT3);
          pan_we  = inr && (cd1 == mtep_pkg::CC_PAN);
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= mtep_pkg::PH_DELTA;
      rs_r    <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      meta_r  <= '0;
      latch_r <= '0;
      tempo_r <= mtep_pkg::TEMPO_RESET;
      halt_r  <= 1'b0;
    end else begin
      ph_r    <= ph_nxt;
      rs_r    <= rs_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      meta_r  <= meta_nxt;
      latch_r <= latch_nxt;
      tempo_r <= tempo_nxt;
      halt_r  <= halt_nxt;
    end
  end

  // Key map and per-channel settings; all cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        key_map_r[i] <= '0;
        prog_r[i]    <= '0;
        bank_r[i]    <= '0;
        pan_r[i]     <= '0;
        fx1_r[i]     <= '0;
        fx3_r[i]     <= '0;
      end
    end else begin
      if (key_we) begin
        key_map_r[ch_idx][key_idx] <= key_on;
      end
      if (prog_we) begin
        prog_r[ch_idx] <= cd1[6:0];
      end
      if (bank_we) begin
        bank_r[ch_idx] <= cd2[6:0];
      end
      if (pan_we) begin
        pan_r[ch_idx] <= cd2[6:0];
      end
      if (fx1_we) begin
        fx1_r[ch_idx] <= cd2[6:0];
      end
      if (fx3_we) begin
        fx3_r[ch_idx] <= cd2[6:0];
      end
    end
  end

endmodule

### rtl/core/mtep_back.sv
// Result back end: drains the command queue, applies volume writes, scales
// volumes and expands refresh requests into one message per channel. Uses mtep_pkg.
module mtep_back #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mtep_pkg::cmd_t      head,
  input  logic                empty,
  output logic                pop,
  input  logic [7:0]          vol_scale,
  output logic                out_valid,
  input  logic                out_stall,
  output mtep_pkg::out_item_t out_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  mtep_pkg::bk_state_t state_r, state_nxt;
  logic [CH_W-1:0]     ch_r;
  logic [6:0]          vol_r [NUM_CHANNELS];
  logic                out_valid_r;
  mtep_pkg::out_item_t out_data_r, out_nxt;
  logic                can_load, load, last_ch;
  logic [7:0]          scale_in;
  logic [15:0]         prod;
  logic [6:0]          scaled;

  assign can_load  = !out_valid_r || !out_stall;
  assign last_ch   = (ch_r == CH_W'(NUM_CHANNELS - 1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Volume scaling by volume_scale/128, clamped.
  assign scale_in = (state_r == mtep_pkg::BK_REFRESH) ? {1'b0, vol_r[ch_r]} : head.data2;
  assign prod     = 16'(scale_in) * 16'(vol_scale);
  assign scaled   = (prod[15:7] > 9'(mtep_pkg::VOL_MAX)) ? mtep_pkg::VOL_MAX : prod[13:7];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtep_pkg::BK_IDLE: begin
        if (!empty && can_load && head.refresh) begin
          state_nxt = mtep_pkg::BK_REFRESH;
        end
      end
      mtep_pkg::BK_REFRESH: begin
        if (can_load && last_ch) begin
          state_nxt = mtep_pkg::BK_IDLE;
        end
      end
      default: state_nxt = mtep_pkg::BK_IDLE;
    endcase
  end

  // Outputs: queue pop, output register load and its contents.
  always_comb begin
    pop     = 1'b0;
    load    = 1'b0;
    out_nxt = '0;
    case (state_r)
      mtep_pkg::BK_IDLE: begin
        pop           = !empty && can_load;
        load          = pop && !head.refresh;
        out_nxt.kind   = head.kind;
        out_nxt.status = head.status;
        out_nxt.data1  = head.data1;
        out_nxt.data2  = head.scale ? scaled : head.data2[6:0];
        out_nxt.value  = head.value;
        out_nxt.last   = head.last;
      end
      mtep_pkg::BK_REFRESH: begin
        load           = can_load;
        out_nxt.kind   = mtep_pkg::KIND_SHORT;
        out_nxt.status = {mtep_pkg::HI_CTRL, 4'(ch_r)};
        out_nxt.data1  = mtep_pkg::CC_VOLUME;
        out_nxt.data2  = scaled;
        out_nxt.last   = last_ch;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_nxt;
    end
  end

  // Control registers and the channel volume store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtep_pkg::BK_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        vol_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop && head.refresh) begin
        ch_r <= '0;
      end else if (state_r == mtep_pkg::BK_REFRESH && can_load) begin
        ch_r <= ch_r + 1'b1;
      end
      if (pop && head.vol_we) begin
        vol_r[CH_W'(head.vol_ch)] <= head.vol_val;
      end
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == mtep_pkg::BK_IDLE)
    else $error("queue popped during a refresh");
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mtep_pkg::BK_REFRESH |-> 32'(ch_r) < NUM_CHANNELS)
    else $error("refresh channel out of range");
  a_refresh_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtep_pkg::BK_REFRESH && can_load && last_ch)
      |=> (state_r == mtep_pkg::BK_IDLE && out_valid_r && out_data_r.last))
    else $error("refresh did not end on its last channel");

endmodule

### rtl/core/midi_track_event_parser_unit.sv
// MIDI track event parser, top level: configuration registers, parser front,
// command queue and result back end. Depends on mtep_pkg and the mtep_* modules.
// Throughput: one item per cycle while the queue has room; a refresh holds the
// back end, without popping the queue, while it sends one volume message per
// channel. Path: a result is written into the command queue at the input
// transfer and then loaded into the output register when the queue is popped.
// Reset (synchronous, rst_n low) clears parse state, key map and channel values.
module midi_track_event_parser_unit #(
  parameter int NUM_CHANNELS = 16,
  parameter int VLQ_BITS     = 28,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mtep_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mtep_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  logic [7:0]          cfg_wdata
);

  logic [6:0]     transpose_r;
  logic [7:0]     vol_scale_r;
  logic           fire, push, pop, empty, full;
  mtep_pkg::cmd_t cmd, head;

  assign in_stall = full;
  assign fire     = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transpose_r <= '0;
      vol_scale_r <= mtep_pkg::VOL_SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        mtep_pkg::CFG_TRANSPOSE: transpose_r <= cfg_wdata[6:0];
        mtep_pkg::CFG_VOL_SCALE: vol_scale_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mtep_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .VLQ_BITS     (VLQ_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_data),
    .transpose (transpose_r),
    .push      (push),
    .cmd       (cmd)
  );

  mtep_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  mtep_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .vol_scale (vol_scale_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
